// ===== rtl/core/sfc_pkg.sv =====
// Shared types, constants and the CRC byte step for the sample packet framer.
`default_nettype none
package sfc_pkg;

    localparam int unsigned SFC_QUEUE_DEPTH = 2;

    localparam logic [15:0] CRC_POLY = 16'h1021;
    localparam logic [15:0] CRC_INIT = 16'hFFFF;

    localparam logic [4:0]  HDR_BYTES    = 5'd16;
    localparam logic [4:0]  SAMPLE_BYTES = 5'd2;
    localparam logic [17:0] FRAME_FIXED  = 18'd18;
    localparam logic [17:0] CAP_RESET    = 18'd131088;

    localparam logic [1:0] CFG_MAGIC_FIRST  = 2'd0;
    localparam logic [1:0] CFG_MAGIC_SECOND = 2'd1;
    localparam logic [1:0] CFG_VERSION      = 2'd2;
    localparam logic [1:0] CFG_CAPACITY     = 2'd3;

    localparam logic FUNC_START  = 1'b0;
    localparam logic FUNC_SAMPLE = 1'b1;

    typedef enum logic [1:0] {
        KIND_ERR    = 2'd0,
        KIND_START  = 2'd1,
        KIND_SAMPLE = 2'd2
    } t_kind;

    typedef struct packed {
        logic        func;
        logic [31:0] seq;
        logic [31:0] time_us;
        logic [15:0] count;
        logic [15:0] sample;
    } t_in_item;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last;
        logic       end_of_packet;
        logic       error;
    } t_out_item;

    typedef struct packed {
        logic [7:0]  magic_first;
        logic [7:0]  magic_second;
        logic [7:0]  protocol_version;
        logic [17:0] capacity_bytes;
    } t_cfg;

    typedef struct packed {
        t_kind       kind;
        logic        close;
        logic [31:0] seq;
        logic [31:0] time_us;
        logic [15:0] count;
        logic [15:0] sample;
    } t_cmd;

    function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int i = 0; i < 8; i++) begin
            c = c[15] ? ((c << 1) ^ CRC_POLY) : (c << 1);
        end
        return c;
    endfunction

endpackage
`default_nettype wire

// ===== rtl/core/sample_packet_framer_crc16.sv =====
// Top level of the sample packet framer: configuration registers and the front/back pipeline.
//
//  channel  direction  handshake              payload
//  input    in         push / full            i_in   (t_in_item)
//  result   out        empty / pop            o_out  (t_out_item)
//  config   in         i_cfg_we, i_cfg_idx    i_cfg_wdata (18 bits)
//
//  One byte leaves per cycle unless the result stalls; a sample item gives 2 bytes, a start 16,
//  an error 1, plus 2 more when the item closes the packet; the byte sequencer sets this.
//  An accepted item enters the command queue; its first byte is then registered at the output.
//  Reset is synchronous and active low; it closes any packet, empties the queue and the output.
//  A stalled result holds; the command queue (QUEUE_DEPTH items) absorbs input meanwhile.
`default_nettype none
module sample_packet_framer_crc16
    import sfc_pkg::*;
#(
    parameter int unsigned QUEUE_DEPTH = SFC_QUEUE_DEPTH
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        push,
    output logic             full,
    input  wire t_in_item    i_in,
    output logic             empty,
    input  wire logic        pop,
    output t_out_item        o_out,
    input  wire logic        i_cfg_we,
    input  wire logic [1:0]  i_cfg_idx,
    input  wire logic [17:0] i_cfg_wdata
);

    t_cfg r_cfg;
    t_cmd front_cmd;
    t_cmd head_cmd;
    logic q_full;
    logic q_empty;
    logic q_pop;
    logic accept;

    assign full   = q_full;
    assign accept = push && !q_full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.magic_first      <= 8'h00;
            r_cfg.magic_second     <= 8'h00;
            r_cfg.protocol_version <= 8'h00;
            r_cfg.capacity_bytes   <= CAP_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_MAGIC_FIRST:  r_cfg.magic_first      <= i_cfg_wdata[7:0];
                CFG_MAGIC_SECOND: r_cfg.magic_second     <= i_cfg_wdata[7:0];
                CFG_VERSION:      r_cfg.protocol_version <= i_cfg_wdata[7:0];
                CFG_CAPACITY:     r_cfg.capacity_bytes   <= i_cfg_wdata;
                default:          r_cfg <= r_cfg;
            endcase
        end
    end

    sfc_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_item   (i_in),
        .i_cfg    (r_cfg),
        .o_cmd    (front_cmd)
    );

    sfc_cmd_q #(
        .DEPTH (QUEUE_DEPTH)
    ) u_cmd_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (accept),
        .i_cmd   (front_cmd),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_empty (q_empty),
        .o_cmd   (head_cmd)
    );

    sfc_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_empty (q_empty),
        .i_cmd       (head_cmd),
        .i_cfg       (r_cfg),
        .o_cmd_pop   (q_pop),
        .i_pop       (pop),
        .o_empty     (empty),
        .o_out       (o_out)
    );

endmodule
`default_nettype wire

// ===== rtl/core/sfc_front.sv =====
// Front end: accepts items, tracks the open packet and classifies each item.
`default_nettype none
module sfc_front
    import sfc_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_accept,
    input  wire t_in_item i_item,
    input  wire t_cfg     i_cfg,
    output t_cmd          o_cmd
);

    logic        r_open;
    logic [15:0] r_left;
    logic        n_open;
    logic [15:0] n_left;
    logic [17:0] total;
    t_cmd        cmd;

    assign total = FRAME_FIXED + {1'b0, i_item.count, 1'b0};

    always_comb begin
        n_open       = r_open;
        n_left       = r_left;
        cmd.kind     = KIND_ERR;
        cmd.close    = 1'b0;
        cmd.seq      = i_item.seq;
        cmd.time_us  = i_item.time_us;
        cmd.count    = i_item.count;
        cmd.sample   = i_item.sample;
        if (i_item.func == FUNC_START) begin
            if (!r_open && (total <= i_cfg.capacity_bytes)) begin
                cmd.kind = KIND_START;
                if (i_item.count == 16'd0) begin
                    cmd.close = 1'b1;
                end else begin
                    n_open = 1'b1;
                    n_left = i_item.count;
                end
            end
        end else if (r_open) begin
            cmd.kind = KIND_SAMPLE;
            n_left   = r_left - 16'd1;
            if (r_left == 16'd1) begin
                cmd.close = 1'b1;
                n_open    = 1'b0;
            end
        end
    end

    assign o_cmd = cmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_open <= 1'b0;
            r_left <= 16'd0;
        end else if (i_accept) begin
            r_open <= n_open;
            r_left <= n_left;
        end
    end

endmodule
`default_nettype wire

// ===== rtl/core/sfc_cmd_q.sv =====
// Short command queue between the front end and the byte sequencer.
`default_nettype none
module sfc_cmd_q
    import sfc_pkg::*;
#(
    parameter int unsigned DEPTH = SFC_QUEUE_DEPTH
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push,
    input  wire t_cmd i_cmd,
    output logic      o_full,
    input  wire logic i_pop,
    output logic      o_empty,
    output t_cmd      o_cmd
);

    localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);

    t_cmd          r_slot [DEPTH];
    logic [PW-1:0] r_wr_ptr;
    logic [PW-1:0] r_rd_ptr;
    logic [CW-1:0] r_count;
    logic          do_push;
    logic          do_pop;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_cmd   = r_slot[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_slot[r_wr_ptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == LAST_PTR) ? '0 : r_wr_ptr + PW'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == LAST_PTR) ? '0 : r_rd_ptr + PW'(1);
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + CW'(1);
            end else if (do_pop && !do_push) begin
                r_count <= r_count - CW'(1);
            end
        end
    end

endmodule
`default_nettype wire

// ===== rtl/core/sfc_back.sv =====
// Back end: walks each command byte by byte, folds the CRC and drives the output register.
`default_nettype none
module sfc_back
    import sfc_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_cmd_empty,
    input  wire t_cmd i_cmd,
    input  wire t_cfg i_cfg,
    output logic      o_cmd_pop,
    input  wire logic i_pop,
    output logic      o_empty,
    output t_out_item o_out
);

    logic [4:0]  r_idx;
    logic [15:0] r_crc;
    logic        r_out_valid;
    t_out_item   r_out;

    logic [4:0]  base;
    logic        advance;
    logic        in_scope;
    logic        crc_hi;
    t_out_item   cur;

    assign advance = !i_cmd_empty && (!r_out_valid || i_pop);
    assign base    = (i_cmd.kind == KIND_START) ? HDR_BYTES : SAMPLE_BYTES;

    always_comb begin
        cur.data_byte     = 8'h00;
        cur.last          = 1'b0;
        cur.end_of_packet = 1'b0;
        cur.error         = 1'b0;
        in_scope          = 1'b0;
        crc_hi            = 1'b0;
        if (i_cmd.kind == KIND_ERR) begin
            cur.last  = 1'b1;
            cur.error = 1'b1;
        end else begin
            cur.last = i_cmd.close ? (r_idx == base + 5'd1) : (r_idx == base - 5'd1);
            if (r_idx == base) begin
                cur.data_byte = r_crc[7:0];
            end else if (r_idx == base + 5'd1) begin
                cur.data_byte     = r_crc[15:8];
                cur.end_of_packet = 1'b1;
                crc_hi            = 1'b1;
            end else if (i_cmd.kind == KIND_START) begin
                in_scope = (r_idx >= 5'd2);
                case (r_idx)
                    5'd0:    cur.data_byte = i_cfg.magic_first;
                    5'd1:    cur.data_byte = i_cfg.magic_second;
                    5'd2:    cur.data_byte = i_cfg.protocol_version;
                    5'd4:    cur.data_byte = i_cmd.seq[7:0];
                    5'd5:    cur.data_byte = i_cmd.seq[15:8];
                    5'd6:    cur.data_byte = i_cmd.seq[23:16];
                    5'd7:    cur.data_byte = i_cmd.seq[31:24];
                    5'd8:    cur.data_byte = i_cmd.time_us[7:0];
                    5'd9:    cur.data_byte = i_cmd.time_us[15:8];
                    5'd10:   cur.data_byte = i_cmd.time_us[23:16];
                    5'd11:   cur.data_byte = i_cmd.time_us[31:24];
                    5'd12:   cur.data_byte = i_cmd.count[7:0];
                    5'd13:   cur.data_byte = i_cmd.count[15:8];
                    default: cur.data_byte = 8'h00;
                endcase
            end else begin
                in_scope      = 1'b1;
                cur.data_byte = r_idx[0] ? i_cmd.sample[15:8] : i_cmd.sample[7:0];
            end
        end
    end

    assign o_cmd_pop = advance && cur.last;
    assign o_empty   = !r_out_valid;
    assign o_out     = r_out;

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out <= cur;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx       <= 5'd0;
            r_crc       <= CRC_INIT;
            r_out_valid <= 1'b0;
        end else begin
            if (advance) begin
                r_out_valid <= 1'b1;
                r_idx       <= cur.last ? 5'd0 : r_idx + 5'd1;
                if (in_scope) begin
                    r_crc <= crc_byte(r_crc, cur.data_byte);
                end else if (crc_hi) begin
                    r_crc <= CRC_INIT;
                end
            end else if (i_pop) begin
                r_out_valid <= 1'b0;
            end
        end
    end

endmodule
`default_nettype wire

// ===== rtl/core/sfc_checker.sv =====
// Port-level checker for the sample packet framer, bound to the top level.
`default_nettype none
module sfc_checker
    import sfc_pkg::*;
(
    input wire logic      i_clk,
    input wire logic      i_rst_n,
    input wire logic      i_empty,
    input wire logic      i_pop,
    input wire t_out_item i_out
);

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!i_empty && !i_pop) |=> (!i_empty && $stable(i_out)))
        else $error("result changed while stalled");

    a_eop_closes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!i_empty && i_out.end_of_packet) |-> (i_out.last && !i_out.error))
        else $error("end of packet without last or with error");

    a_error_form: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!i_empty && i_out.error) |-> (i_out.last && (i_out.data_byte == 8'h00)))
        else $error("malformed error result");

    a_eop_then_new: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!i_empty && i_pop && !i_out.last) |=> (i_empty || !i_out.error))
        else $error("error result inside an item's byte run");

endmodule

bind sample_packet_framer_crc16 sfc_checker u_sfc_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .i_empty (empty),
    .i_pop   (pop),
    .i_out   (o_out)
);
`default_nettype wire

// ===== bench/tb.sv =====
// Testbench for sample_packet_framer_crc16: directed and random items checked against a packet predictor.
`timescale 1ns / 100ps

module tb;
    import sfc_pkg::*;

    localparam logic [15:0] CRC16_SEED  = 16'hFFFF;
    localparam logic [15:0] GEN_POLY    = 16'h1021;
    localparam logic [17:0] CAP_MAX     = 18'd131088;
    localparam int          LONG_HOLD   = 300;
    localparam int          PHASE_ITEMS = 60;
    localparam t_out_item   REJECT      = '{data_byte: 8'h00, last: 1'b1,
                                            end_of_packet: 1'b0, error: 1'b1};

    typedef struct packed {
        logic        is_cfg;
        logic [7:0]  magic1;
        logic [7:0]  magic2;
        logic [7:0]  version;
        logic [17:0] capacity;
        t_in_item    item;
        logic        rejected;
    } t_plan_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        push = 1'b0;
    logic        full;
    t_in_item    i_in = '0;
    logic        empty;
    logic        pop = 1'b0;
    t_out_item   o_out;
    logic        i_cfg_we = 1'b0;
    logic [1:0]  i_cfg_idx = CFG_MAGIC_FIRST;
    logic [17:0] i_cfg_wdata = '0;

    sample_packet_framer_crc16 DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .push       (push),
        .full       (full),
        .i_in       (i_in),
        .empty      (empty),
        .pop        (pop),
        .o_out      (o_out),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_wdata(i_cfg_wdata)
    );

    always #6 i_clk = ~i_clk;

    initial begin
        #7_200_000;
        $display("DONE: errors detected");
        $finish;
    end

    t_out_item   bytes_due[$];
    t_plan_row   plan[$];
    int          errors = 0;
    int          tx_idle_pct = 20;
    int          rx_idle_pct = 20;
    logic        rx_long_hold = 1'b0;
    int          rx_hold_left = 0;
    t_out_item   rx_want;

    logic [7:0]  cfg_magic1 = 8'h00;
    logic [7:0]  cfg_magic2 = 8'h00;
    logic [7:0]  cfg_version = 8'h00;
    logic [17:0] cfg_capacity = CAP_MAX;

    logic        fr_open = 1'b0;
    logic [15:0] fr_left = 16'h0000;
    logic [15:0] fr_crc = CRC16_SEED;

    function automatic logic [15:0] crc16_step(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        logic        fb;
        c = crc;
        for (int k = 7; k >= 0; k--) begin
            fb = c[15] ^ b[k];
            c = {c[14:0], 1'b0} ^ (fb ? GEN_POLY : 16'h0000);
        end
        return c;
    endfunction

    task automatic put_byte(input logic [7:0] b, input logic fold, input logic lst,
                            input logic eop);
        t_out_item r;
        r.data_byte = b;
        r.last = lst;
        r.end_of_packet = eop;
        r.error = 1'b0;
        bytes_due.push_back(r);
        if (fold) begin
            fr_crc = crc16_step(fr_crc, b);
        end
    endtask

    task automatic close_out();
        put_byte(fr_crc[7:0], 1'b0, 1'b0, 1'b0);
        put_byte(fr_crc[15:8], 1'b0, 1'b1, 1'b1);
        fr_open = 1'b0;
        fr_left = 16'h0000;
        fr_crc = CRC16_SEED;
    endtask

    task automatic frame_item(input t_in_item it);
        logic [17:0] total;
        logic [7:0]  hdr [16];
        total = 18'd18 + {1'b0, it.count, 1'b0};
        if (it.func == FUNC_START) begin
            if (fr_open || total > cfg_capacity) begin
                bytes_due.push_back(REJECT);
            end else begin
                hdr[0] = cfg_magic1;
                hdr[1] = cfg_magic2;
                hdr[2] = cfg_version;
                hdr[3] = 8'h00;
                for (int k = 0; k < 4; k++) begin
                    hdr[4 + k] = it.seq[8 * k +: 8];
                    hdr[8 + k] = it.time_us[8 * k +: 8];
                end
                hdr[12] = it.count[7:0];
                hdr[13] = it.count[15:8];
                hdr[14] = 8'h00;
                hdr[15] = 8'h00;
                fr_crc = CRC16_SEED;
                for (int k = 0; k < 16; k++) begin
                    put_byte(hdr[k], k >= 2, k == 15 && it.count != 16'h0000, 1'b0);
                end
                if (it.count == 16'h0000) begin
                    close_out();
                end else begin
                    fr_open = 1'b1;
                    fr_left = it.count;
                end
            end
        end else if (!fr_open) begin
            bytes_due.push_back(REJECT);
        end else begin
            fr_left = fr_left - 16'd1;
            put_byte(it.sample[7:0], 1'b1, 1'b0, 1'b0);
            put_byte(it.sample[15:8], 1'b1, fr_left != 16'h0000, 1'b0);
            if (fr_left == 16'h0000) begin
                close_out();
            end
        end
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [17:0] val);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_wdata <= val;
        @(posedge i_clk);
    endtask

    task automatic program_regs(input logic [7:0] m1, input logic [7:0] m2,
                                input logic [7:0] ver, input logic [17:0] cap);
        write_reg(CFG_MAGIC_FIRST, {10'd0, m1});
        write_reg(CFG_MAGIC_SECOND, {10'd0, m2});
        write_reg(CFG_VERSION, {10'd0, ver});
        write_reg(CFG_CAPACITY, cap);
        i_cfg_we <= 1'b0;
        cfg_magic1 = m1;
        cfg_magic2 = m2;
        cfg_version = ver;
        cfg_capacity = cap;
    endtask

    task automatic wait_idle();
        push <= 1'b0;
        @(posedge i_clk);
        while (bytes_due.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (6) @(posedge i_clk);
    endtask

    task automatic send_item(input t_in_item it, input logic rejected);
        if (tx_idle_pct != 0 && $urandom_range(99) < tx_idle_pct) begin
            push <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge i_clk);
        end
        push <= 1'b1;
        i_in <= it;
        @(posedge i_clk);
        while (full) begin
            @(posedge i_clk);
        end
        if (rejected) begin
            bytes_due.push_back(REJECT);
        end else begin
            frame_item(it);
        end
    endtask

    task automatic next_item(output t_in_item it);
        int          pick;
        logic [17:0] room;
        pick = $urandom_range(99);
        it.seq = $urandom;
        it.time_us = $urandom;
        it.count = 16'($urandom);
        it.sample = (pick % 13 == 0) ? 16'hFFFF : (pick % 11 == 0) ? 16'h0000 : 16'($urandom);
        room = (cfg_capacity >= 18'd18) ? (cfg_capacity - 18'd18) >> 1 : 18'd0;
        if (fr_open) begin
            it.func = (pick < 6) ? FUNC_START : FUNC_SAMPLE;
        end else if (pick < 10) begin
            it.func = FUNC_SAMPLE;
        end else begin
            it.func = FUNC_START;
            if (pick < 20) begin
                if (room >= {2'b00, it.count} && it.count > 16'd40) begin
                    it.count = it.count % 16'd8;
                end
            end else begin
                it.count = ($urandom_range(99) < 70) ? 16'($urandom_range(0, 6))
                                                     : 16'($urandom_range(7, 40));
                if (cfg_capacity >= 18'd18 && {2'b00, it.count} > room) begin
                    it.count = room[15:0];
                end
            end
        end
    endtask

    task automatic add_regs(input logic [7:0] m1, input logic [7:0] m2,
                            input logic [7:0] ver, input logic [17:0] cap);
        t_plan_row row;
        row = '0;
        row.is_cfg = 1'b1;
        row.magic1 = m1;
        row.magic2 = m2;
        row.version = ver;
        row.capacity = cap;
        plan.push_back(row);
    endtask

    task automatic add_start(input logic [31:0] seq, input logic [31:0] tus,
                             input logic [15:0] cnt, input logic rejected);
        t_plan_row row;
        row = '0;
        row.item.func = FUNC_START;
        row.item.seq = seq;
        row.item.time_us = tus;
        row.item.count = cnt;
        row.rejected = rejected;
        plan.push_back(row);
    endtask

    task automatic add_sample(input logic [15:0] smp, input logic rejected);
        t_plan_row row;
        row = '0;
        row.item.func = FUNC_SAMPLE;
        row.item.sample = smp;
        row.rejected = rejected;
        plan.push_back(row);
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && pop && !empty) begin
            if (bytes_due.size() == 0) begin
                $error("unexpected result: data_byte %0h", o_out.data_byte);
                errors++;
            end else begin
                rx_want = bytes_due.pop_front();
                if (o_out.data_byte !== rx_want.data_byte) begin
                    $error("data_byte: expected %0h, got %0h", rx_want.data_byte, o_out.data_byte);
                    errors++;
                end
                if (o_out.last !== rx_want.last) begin
                    $error("last: expected %0b, got %0b", rx_want.last, o_out.last);
                    errors++;
                end
                if (o_out.end_of_packet !== rx_want.end_of_packet) begin
                    $error("end_of_packet: expected %0b, got %0b",
                           rx_want.end_of_packet, o_out.end_of_packet);
                    errors++;
                end
                if (o_out.error !== rx_want.error) begin
                    $error("error: expected %0b, got %0b", rx_want.error, o_out.error);
                    errors++;
                end
            end
        end
        if (!i_rst_n) begin
            pop <= 1'b0;
        end else if (rx_hold_left > 0) begin
            rx_hold_left--;
            pop <= 1'b0;
        end else if (rx_long_hold) begin
            rx_long_hold = 1'b0;
            rx_hold_left = LONG_HOLD;
            pop <= 1'b0;
        end else if (rx_idle_pct != 0 && $urandom_range(99) < rx_idle_pct) begin
            rx_hold_left = $urandom_range(0, 12);
            pop <= 1'b0;
        end else begin
            pop <= 1'b1;
        end
    end

    initial begin
        t_in_item it;
        int       pick;

        add_sample(16'h1234, 1'b1);
        add_start(32'h0000_0000, 32'h0000_0000, 16'h0000, 1'b0);
        add_start(32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'h0002, 1'b0);
        add_start(32'h0000_0001, 32'h0000_0002, 16'h0001, 1'b1);
        add_sample(16'h0000, 1'b0);
        add_sample(16'hFFFF, 1'b0);
        add_regs(8'hFF, 8'hFF, 8'hFF, 18'd18);
        add_start(32'h1234_5678, 32'h9ABC_DEF0, 16'h0000, 1'b0);
        add_start(32'h0000_0000, 32'h0000_0000, 16'h0001, 1'b1);
        add_sample(16'h5555, 1'b1);
        add_regs(8'h00, 8'h00, 8'h00, 18'd0);
        add_start(32'h0000_0000, 32'h0000_0000, 16'h0000, 1'b1);
        add_regs(8'h00, 8'h00, 8'h00, CAP_MAX - 18'd1);
        add_start(32'h0000_0000, 32'h0000_0000, 16'hFFFF, 1'b1);
        add_regs(8'hA5, 8'h5A, 8'h01, 18'd22);
        add_start(32'h8000_0001, 32'h0000_0001, 16'h0002, 1'b0);
        add_start(32'h0000_0007, 32'h0000_0007, 16'h0002, 1'b1);
        add_sample(16'h8001, 1'b0);
        add_sample(16'h7FFE, 1'b0);
        add_start(32'h0000_0000, 32'h0000_0000, 16'h0003, 1'b1);

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (plan[n]) begin
            if (plan[n].is_cfg) begin
                wait_idle();
                program_regs(plan[n].magic1, plan[n].magic2, plan[n].version, plan[n].capacity);
            end else begin
                send_item(plan[n].item, plan[n].rejected);
            end
        end

        for (int ph = 0; ph < 6; ph++) begin
            wait_idle();
            pick = $urandom_range(2);
            if (ph == 5) begin
                program_regs(8'($urandom), 8'($urandom), 8'($urandom), CAP_MAX);
                tx_idle_pct = 0;
                rx_idle_pct = 0;
            end else begin
                program_regs(8'($urandom), 8'($urandom), 8'($urandom),
                             (pick == 0) ? 18'($urandom_range(18, 120)) :
                             (pick == 1) ? 18'($urandom_range(0, 131088)) : CAP_MAX);
                tx_idle_pct = (ph == 3) ? 0 : 10 * $urandom_range(0, 5);
                rx_idle_pct = (ph == 3) ? 0 : 10 * $urandom_range(0, 5);
            end
            if (ph == 1) begin
                rx_long_hold = 1'b1;
            end
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if (ph == 2 && n == PHASE_ITEMS / 2) begin
                    wait_idle();
                end
                next_item(it);
                send_item(it, 1'b0);
            end
            while (fr_open) begin
                next_item(it);
                send_item(it, 1'b0);
            end
        end

        wait_idle();
        repeat (20) @(posedge i_clk);
        if (errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
